### rtl/core/binary_max_heap_build_insert_assert.svh
// Assertion macros for the binary max-heap block.
// Uses clk_i and rst_ni of the including module; empty for synthesis.
`ifndef BINARY_MAX_HEAP_BUILD_INSERT_ASSERT_SVH
`define BINARY_MAX_HEAP_BUILD_INSERT_ASSERT_SVH
`ifndef SYNTHESIS
`define BMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BMH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BMH_ASSERT(lbl, prop, msg)
`define BMH_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/core/bmh_pkg.sv
// Package for the binary max-heap block: sequencer states, action and status codes.
// No dependencies.
`timescale 1ns / 1ps
package bmh_pkg;

  localparam int unsigned HeapSlotsDef = 1024;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned CountOutW    = 10;

  localparam logic [1:0] ActLoad   = 2'd0;
  localparam logic [1:0] ActBuild  = 2'd1;
  localparam logic [1:0] ActInsert = 2'd2;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatEmpty = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StDecode,
    StInsRd,
    StInsCmp,
    StSdLoad,
    StSdCur,
    StSdChk,
    StSdLeft,
    StSdRight,
    StSdCmp,
    StSdEnd,
    StResp
  } bmh_state_e;

endpackage

### rtl/core/bmh_cmp.sv
// Shared signed key comparator of the heap sequencer.
// Depends on bmh_pkg for the key width.
`timescale 1ns / 1ps
module bmh_cmp (
  input  logic signed [bmh_pkg::KeyW-1:0] a_i,
  input  logic signed [bmh_pkg::KeyW-1:0] b_i,
  output logic                            gt_o
);
  import bmh_pkg::*;

  assign gt_o = (a_i > b_i);

endmodule

### rtl/core/binary_max_heap_build_insert.sv
// Top level of the binary max-heap: sequencer, key memory and root register.
// Depends on bmh_pkg, bmh_cmp and binary_max_heap_build_insert_assert.svh.
//
//   channel   signals                                      handshake
//   command   action_i, key_value_i                        start_i && !busy_o
//   result    top_key_o, top_valid_o, entry_count_o,       done_o, one cycle
//             status_o
//
// Load, unused and rejected actions and a build of under two entries end after decode.
// Insert compares the key with one parent per level climbed, up to the root at most.
// Build sifts each parent down in turn: it reads the parent, compares it with one or both
// children per level and writes it back where its sift stops.
// Reset clears the count and the sequencer; the key memory needs no clearing.
// done_o is a one-cycle strobe; busy_o stays high from accept to done_o.
`timescale 1ns / 1ps
`include "binary_max_heap_build_insert_assert.svh"
module binary_max_heap_build_insert #(
  parameter int unsigned HEAP_SLOTS = bmh_pkg::HeapSlotsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           action_i,
  input  logic signed [bmh_pkg::KeyW-1:0]      key_value_i,
  output logic                                 done_o,
  output logic signed [bmh_pkg::KeyW-1:0]      top_key_o,
  output logic                                 top_valid_o,
  output logic [bmh_pkg::CountOutW-1:0]        entry_count_o,
  output logic [1:0]                           status_o
);
  import bmh_pkg::*;

  localparam int unsigned CW = $clog2(HEAP_SLOTS);

  bmh_state_e state_q, state_d;

  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          par_q, par_d;
  logic [CW-1:0]          child_q, child_d;
  logic [1:0]             act_q;
  logic [1:0]             status_q, status_d;
  logic signed [KeyW-1:0] key_q;
  logic signed [KeyW-1:0] cur_q, cur_d;
  logic signed [KeyW-1:0] best_q, best_d;
  logic signed [KeyW-1:0] top_q;

  logic signed [KeyW-1:0] mem [HEAP_SLOTS];
  logic signed [KeyW-1:0] rdata_q;
  logic                   mem_we;
  logic [CW-1:0]          mem_waddr;
  logic signed [KeyW-1:0] mem_wdata;
  logic [CW-1:0]          mem_raddr;

  logic signed [KeyW-1:0] cmp_a, cmp_b;
  logic                   gt;

  logic                   full;
  logic [CW-1:0]          half_cnt;
  logic [CW-1:0]          left_addr;
  logic [CW:0]            right_ext;
  logic                   right_ok;
  logic [31:0]            cnt32;

  assign full      = (count_q == CW'(HEAP_SLOTS - 1));
  assign half_cnt  = count_q >> 1;
  assign left_addr = pos_q << 1;
  assign right_ext = {pos_q, 1'b1};
  assign right_ok  = (right_ext <= {1'b0, count_q});

  bmh_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .gt_o (gt)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (start_i) state_d = StDecode;
      StDecode: begin
        case (act_q)
          ActLoad:   state_d = StResp;
          ActInsert: state_d = full ? StResp : StInsRd;
          ActBuild:  state_d = (half_cnt == '0) ? StResp : StSdLoad;
          default:   state_d = StResp;
        endcase
      end
      StInsRd:   state_d = (pos_q == CW'(1)) ? StResp : StInsCmp;
      StInsCmp:  state_d = gt ? StInsRd : StResp;
      StSdLoad:  state_d = StSdCur;
      StSdCur:   state_d = StSdChk;
      StSdChk:   state_d = (pos_q > half_cnt) ? StSdEnd : StSdLeft;
      StSdLeft:  state_d = right_ok ? StSdRight : StSdCmp;
      StSdRight: state_d = StSdCmp;
      StSdCmp:   state_d = gt ? StSdChk : StSdEnd;
      StSdEnd:   state_d = (par_q == CW'(1)) ? StResp : StSdLoad;
      StResp:    state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // Outputs: handshake, memory port and comparator operands
  always_comb begin
    busy_o    = (state_q != StIdle);
    done_o    = (state_q == StResp);
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = key_q;
    mem_raddr = pos_q;
    cmp_a     = best_q;
    cmp_b     = cur_q;
    unique case (state_q)
      StDecode: begin
        if (act_q == ActLoad && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count_q + CW'(1);
        end
      end
      StInsRd: begin
        mem_raddr = pos_q >> 1;
        mem_we    = (pos_q == CW'(1));
      end
      StInsCmp: begin
        cmp_a     = key_q;
        cmp_b     = rdata_q;
        mem_we    = 1'b1;
        mem_wdata = gt ? rdata_q : key_q;
      end
      StSdChk:   mem_raddr = left_addr;
      StSdLeft:  mem_raddr = right_ext[CW-1:0];
      StSdRight: begin
        cmp_a = rdata_q;
        cmp_b = best_q;
      end
      StSdCmp: begin
        mem_we    = gt;
        mem_wdata = best_q;
      end
      StSdEnd: begin
        mem_we    = 1'b1;
        mem_wdata = cur_q;
      end
      default: ;
    endcase
  end

  // Datapath register updates
  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    par_d    = par_q;
    child_d  = child_q;
    status_d = status_q;
    cur_d    = cur_q;
    best_d   = best_q;
    case (state_q)
      StDecode: begin
        status_d = StatOk;
        case (act_q)
          ActLoad: begin
            if (full) status_d = StatFull;
            else count_d = count_q + CW'(1);
          end
          ActInsert: begin
            if (full) begin
              status_d = StatFull;
            end else begin
              count_d = count_q + CW'(1);
              pos_d   = count_q + CW'(1);
            end
          end
          ActBuild: begin
            if (count_q == '0) status_d = StatEmpty;
            par_d = half_cnt;
            pos_d = half_cnt;
          end
          default: ;
        endcase
      end
      StInsCmp:  if (gt) pos_d = pos_q >> 1;
      StSdCur:   cur_d = rdata_q;
      StSdLeft: begin
        best_d  = rdata_q;
        child_d = left_addr;
      end
      StSdRight: begin
        if (gt) begin
          best_d  = rdata_q;
          child_d = right_ext[CW-1:0];
        end
      end
      StSdCmp:   if (gt) pos_d = child_q;
      StSdEnd: begin
        par_d = par_q - CW'(1);
        pos_d = par_q - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      act_q <= action_i;
      key_q <= key_value_i;
    end
    pos_q    <= pos_d;
    par_q    <= par_d;
    child_q  <= child_d;
    status_q <= status_d;
    cur_q    <= cur_d;
    best_q   <= best_d;
    // Track the root so the result never waits on a memory read
    if (mem_we && mem_waddr == CW'(1)) top_q <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  assign cnt32         = 32'(count_q);
  assign entry_count_o = cnt32[CountOutW-1:0];
  assign top_valid_o   = (count_q != '0);
  assign top_key_o     = top_valid_o ? top_q : '0;
  assign status_o      = status_q;

  `BMH_ASSERT(a_done_pulse, done_o |=> !done_o, "result strobe longer than one cycle")
  `BMH_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "busy not raised on accept")
  `BMH_NEVER(a_count_max, count_q > CW'(HEAP_SLOTS - 1), "entry count beyond capacity")
  `BMH_ASSERT(a_count_step, $past(state_q) != StDecode |-> $stable(count_q), "count moved outside decode")
  `BMH_NEVER(a_status_code, done_o && status_o != StatOk && status_o != StatFull && status_o != StatEmpty, "bad status code")

endmodule
